// ----- sv/hhf_pkg.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP host filter package
// Shared types and constants for the host header filter.
// ---------------------------------------------------------------------------
package hhf_pkg;

   localparam int MAX_HOST_BYTES = 32;
   localparam int TARGET_BYTES   = 32;
   localparam int TARGET_LEN_W   = 6;
   localparam int CSR_INDEX_W    = 3;
   localparam int CSR_DATA_W     = 64;

   localparam logic [7:0] CR_BYTE = 8'h0D;

   localparam logic [2:0] KEYWORD_LAST = 3'd5;

   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_LENGTH = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_0 = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_1 = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_2 = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TARGET_WORD_3 = 3'd4;

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_SKIP,
      PH_SEARCH,
      PH_COMPARE,
      PH_ACCEPT,
      PH_DROP
   } phase_type;

   typedef struct packed {
      logic [TARGET_LEN_W-1:0]       length;
      logic [TARGET_BYTES-1:0][7:0]  host;
   } target_type;

   // Bytes of the "Host: " keyword.
   function automatic logic [7:0] keyword_byte(input logic [2:0] idx);
      logic [7:0] kb;
      unique case (idx)
         3'd0:    kb = 8'h48;
         3'd1:    kb = 8'h6F;
         3'd2:    kb = 8'h73;
         3'd3:    kb = 8'h74;
         3'd4:    kb = 8'h3A;
         3'd5:    kb = 8'h20;
         3'd7:    kb = 8'h6F;
         default: kb = 8'h48;
      endcase
      return kb;
   endfunction

endpackage

// ----- sv/hhf_target_regs.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP host filter target registers
// Holds the blocked host name and its length, written through the CSR port.
// ---------------------------------------------------------------------------
module hhf_target_regs
   import hhf_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output target_type             target
);

   logic [TARGET_LEN_W-1:0] length_ff;
   logic [CSR_DATA_W-1:0]   word0_ff;
   logic [CSR_DATA_W-1:0]   word1_ff;
   logic [CSR_DATA_W-1:0]   word2_ff;
   logic [CSR_DATA_W-1:0]   word3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         length_ff <= '0;
         word0_ff  <= '0;
         word1_ff  <= '0;
         word2_ff  <= '0;
         word3_ff  <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TARGET_LENGTH: length_ff <= csr_wdata[TARGET_LEN_W-1:0];
            CSR_TARGET_WORD_0: word0_ff  <= csr_wdata;
            CSR_TARGET_WORD_1: word1_ff  <= csr_wdata;
            CSR_TARGET_WORD_2: word2_ff  <= csr_wdata;
            CSR_TARGET_WORD_3: word3_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign target.length = length_ff;
   assign target.host   = {word3_ff, word2_ff, word1_ff, word0_ff};

endmodule

// ----- sv/hhf_parser.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP host filter parser
// Per-byte packet parser: header lengths, keyword search and host compare.
// ---------------------------------------------------------------------------
module hhf_parser
   import hhf_pkg::*;
#(
   parameter int POSITION_BITS = 16
)
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  logic [7:0] packet_byte,
   input  logic       end_of_packet,
   input  target_type target,
   output logic       drop_packet
);

   logic [POSITION_BITS-1:0] byte_position_ff, byte_position_in;
   logic [5:0]               ip_header_bytes_ff, ip_header_bytes_in;
   logic [6:0]               payload_start_ff, payload_start_in;
   phase_type                phase_ff, phase_in;
   logic [2:0]               keyword_progress_ff, keyword_progress_in;
   logic [5:0]               host_index_ff, host_index_in;
   logic                     host_mismatch_ff, host_mismatch_in;

   logic [5:0] ihl_eff;
   logic [6:0] header_end;
   phase_type  phase_eff;

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_position_ff    <= '0;
         ip_header_bytes_ff  <= '0;
         payload_start_ff    <= '0;
         phase_ff            <= PH_HEADER;
         keyword_progress_ff <= '0;
         host_index_ff       <= '0;
         host_mismatch_ff    <= 1'b0;
      end else begin
         byte_position_ff    <= byte_position_in;
         ip_header_bytes_ff  <= ip_header_bytes_in;
         payload_start_ff    <= payload_start_in;
         phase_ff            <= phase_in;
         keyword_progress_ff <= keyword_progress_in;
         host_index_ff       <= host_index_in;
         host_mismatch_ff    <= host_mismatch_in;
      end
   end

   always_comb begin
      byte_position_in    = byte_position_ff;
      ip_header_bytes_in  = ip_header_bytes_ff;
      payload_start_in    = payload_start_ff;
      phase_in            = phase_ff;
      keyword_progress_in = keyword_progress_ff;
      host_index_in       = host_index_ff;
      host_mismatch_in    = host_mismatch_ff;
      ihl_eff             = (byte_position_ff == '0) ? {packet_byte[3:0], 2'b00}
                                                    : ip_header_bytes_ff;
      header_end          = {1'b0, ihl_eff} + 7'd12;
      phase_eff           = phase_ff;
      drop_packet         = 1'b0;

      if (step) begin
         if (phase_ff == PH_HEADER) begin
            ip_header_bytes_in = ihl_eff;
            if (byte_position_ff == POSITION_BITS'(header_end)) begin
               if (packet_byte[7:6] == 2'b00) begin
                  phase_in = PH_ACCEPT;
               end else begin
                  payload_start_in = {1'b0, ihl_eff} + {1'b0, packet_byte[7:4], 2'b00};
                  phase_in         = PH_SKIP;
               end
            end
         end else begin
            if (phase_ff == PH_SKIP &&
                byte_position_ff >= POSITION_BITS'(payload_start_ff)) begin
               phase_eff = PH_SEARCH;
            end
            phase_in = phase_eff;
            if (phase_eff == PH_SEARCH) begin
               if (packet_byte == keyword_byte(keyword_progress_ff)) begin
                  if (keyword_progress_ff >= KEYWORD_LAST) begin
                     keyword_progress_in = '0;
                     host_index_in       = '0;
                     host_mismatch_in    = 1'b0;
                     phase_in            = PH_COMPARE;
                  end else begin
                     keyword_progress_in = keyword_progress_ff + 3'd1;
                  end
               end else begin
                  keyword_progress_in = (packet_byte == keyword_byte(3'd0)) ? 3'd1 : 3'd0;
               end
            end else if (phase_eff == PH_COMPARE) begin
               if (packet_byte == CR_BYTE) begin
                  phase_in = (!host_mismatch_ff && host_index_ff == target.length)
                             ? PH_DROP : PH_ACCEPT;
               end else begin
                  if (host_index_ff >= target.length ||
                      {1'b0, host_index_ff} >= 7'(MAX_HOST_BYTES) ||
                      packet_byte != target.host[host_index_ff[4:0]]) begin
                     host_mismatch_in = 1'b1;
                  end
                  if (host_index_ff != 6'd63) begin
                     host_index_in = host_index_ff + 6'd1;
                  end
               end
            end
         end

         if (byte_position_ff != '1) begin
            byte_position_in = byte_position_ff + 1'b1;
         end

         if (end_of_packet) begin
            drop_packet         = (phase_in == PH_DROP);
            byte_position_in    = '0;
            ip_header_bytes_in  = '0;
            payload_start_in    = '0;
            phase_in            = PH_HEADER;
            keyword_progress_in = '0;
            host_index_in       = '0;
            host_mismatch_in    = 1'b0;
         end
      end
   end

   a_keyword_range: assert property (@(posedge clock) disable iff (reset)
      keyword_progress_ff <= KEYWORD_LAST)
      else $error("Keyword progress out of range.");

   a_drop_clean: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_DROP |-> !host_mismatch_ff)
      else $error("Drop verdict held with a host mismatch.");

   a_packet_clear: assert property (@(posedge clock) disable iff (reset)
      step && end_of_packet |=> byte_position_ff == '0 && phase_ff == PH_HEADER)
      else $error("Parser state not cleared after the last item.");

endmodule

// ----- sv/http_host_filter_core.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// HTTP host filter core
// Streams IPv4/TCP packet bytes and drops packets whose Host header matches
// the configured target host.
// ---------------------------------------------------------------------------
// Channel   Direction  Ports                                   Moves
// req       in         req_valid, req_stall, req_packet_byte,   one packet byte
//                      req_end_of_packet
// rsp       out        rsp_valid, rsp_stall, rsp_drop_packet    one verdict
// csr       in         csr_wr_en, csr_index, csr_wdata          register write
//
// One item is accepted per cycle while req_stall is low; the last item of a
// packet passes the input register, and its verdict is set in the result register.
// A stalled verdict holds the output register; items that end no packet
// keep flowing past it, and only the last item of a packet waits.
// Reset clears the parser, the target registers and the valid flags of both
// stage registers.
// ---------------------------------------------------------------------------
module http_host_filter_core
   import hhf_pkg::*;
#(
   parameter int POSITION_BITS = 16
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_packet_byte,
   input  logic                   req_end_of_packet,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_drop_packet,
   input  logic                   csr_wr_en,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eop_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_drop_ff;
   logic       fire;
   logic       accept;
   logic       verdict;
   target_type target;

   assign fire      = in_valid_ff && (!in_eop_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !fire;
   assign accept    = req_valid && !req_stall;

   assign in_valid_in  = accept || (in_valid_ff && !fire);
   assign rsp_valid_in = (fire && in_eop_ff) || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_packet_byte;
         in_eop_ff  <= req_end_of_packet;
      end
      if (fire && in_eop_ff) begin
         rsp_drop_ff <= verdict;
      end
   end

   hhf_target_regs u_target_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .target    (target)
   );

   hhf_parser #(
      .POSITION_BITS (POSITION_BITS)
   ) u_parser (
      .clock         (clock),
      .reset         (reset),
      .step          (fire),
      .packet_byte   (in_byte_ff),
      .end_of_packet (in_eop_ff),
      .target        (target),
      .drop_packet   (verdict)
   );

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drop_packet = rsp_drop_ff;

   a_verdict_follows: assert property (@(posedge clock) disable iff (reset)
      fire && in_eop_ff |=> rsp_valid_ff)
      else $error("Last item of a packet produced no verdict.");

   a_verdict_source: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !$past(rsp_valid_ff && rsp_stall) |-> $past(fire && in_eop_ff))
      else $error("Verdict appeared without a last item.");

   a_input_hold: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !fire |=> in_valid_ff && $stable(in_byte_ff) && $stable(in_eop_ff))
      else $error("Waiting item lost or changed in the input register.");

endmodule
